// File: design/sfmc_pkg.sv
// Shared types, constants and codes for the saw feed motor controller.
package sfmc_pkg;

  localparam int unsigned AdcBits  = 12;
  localparam int unsigned AccelW   = 16;
  localparam int unsigned PwmW     = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgAddrW = 2;

  // Shared divider: quotient is known to stay below 2**QuoW.
  localparam int unsigned QuoW     = PwmW;
  localparam int unsigned DivDenW  = (AccelW > AdcBits) ? AccelW : AdcBits;
  localparam int unsigned DivNumW  = DivDenW + QuoW;
  localparam int unsigned DivCntW  = $clog2(QuoW);

  // Blink counter kept as a digit pair: ticks mod 100 and hundreds of ticks mod 10.
  localparam int unsigned SubW     = 7;
  localparam int unsigned HundW    = 4;
  localparam logic [SubW-1:0]  SubLast   = SubW'(99);
  localparam logic [SubW-1:0]  SubHalf   = SubW'(50);
  localparam logic [HundW-1:0] HundLast  = HundW'(9);
  localparam logic [HundW-1:0] HundHalf  = HundW'(5);

  localparam logic [PwmW-1:0]     FullSpeed    = PwmW'(255);
  localparam logic [AccelW-1:0]   AccelReset   = AccelW'(500);
  localparam logic [AdcBits-1:0]  FeedLowReset = AdcBits'(5);
  localparam logic [AdcBits-1:0]  FeedHiReset  = AdcBits'(4060);
  localparam logic [PwmW-1:0]     UpSpeedReset = PwmW'(255);
  localparam logic [AccelW-1:0]   ElapsedMax   = '1;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_UP    = 2'd1,
    MODE_DOWN  = 2'd2,
    MODE_ESTOP = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    LED_OFF         = 3'd0,
    LED_ON          = 3'd1,
    LED_BLINK_SLOW  = 3'd2,
    LED_BLINK_FAST  = 3'd3,
    LED_BLINK_RAPID = 3'd4
  } led_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_ACCEL_MS      = 2'd0,
    CFG_FEED_ADC_LOW  = 2'd1,
    CFG_FEED_ADC_HIGH = 2'd2,
    CFG_UP_SPEED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FEED_DIV,
    ST_TARGET,
    ST_RAMP_DIV,
    ST_RAMP_END,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               estop_held;
    logic               estop_released;
    logic               up_held;
    logic               up_short_release;
    logic               up_long_press;
    logic               down_held;
    logic               down_short_release;
    logic               down_long_press;
    logic               top_limit_hit;
    logic               bottom_limit_hit;
    logic [AdcBits-1:0] feed_adc;
  } in_t;

  typedef struct packed {
    logic [PwmW-1:0] motor_pwm;
    logic            drive_up;
    logic            drive_down;
    logic            status_led;
    logic [1:0]      mode_now;
    logic            auto_active;
  } out_t;

  typedef struct packed {
    logic latch_in;
    logic eval;
    logic feed_load;
    logic div_step;
    logic target;
    logic ramp_load;
    logic ramp_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic move;
    logic feed_need;
    logic ramp_need;
  } sts_t;

endpackage

// File: design/sfmc_div.sv
// Restoring divider, one quotient bit per step, quotient below 2**QuoW.
module sfmc_div (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic                            step_i,
  input  logic [sfmc_pkg::DivNumW-1:0]    num_i,
  input  logic [sfmc_pkg::DivDenW-1:0]    den_i,
  output logic [sfmc_pkg::QuoW-1:0]       quo_o
);

  localparam int unsigned ShW = sfmc_pkg::DivDenW + sfmc_pkg::QuoW - 1;

  logic [sfmc_pkg::DivNumW-1:0] rem_q, rem_d;
  logic [ShW-1:0]               den_q, den_d;
  logic [sfmc_pkg::QuoW-1:0]    quo_q, quo_d;
  logic [sfmc_pkg::DivNumW-1:0] den_ext;
  logic                         ge;

  assign den_ext = sfmc_pkg::DivNumW'(den_q);
  assign ge      = (rem_q >= den_ext);

  always_comb begin
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    if (load_i) begin
      rem_d = num_i;
      den_d = {den_i, {(sfmc_pkg::QuoW-1){1'b0}}};
      quo_d = '0;
    end else if (step_i) begin
      if (ge) begin
        rem_d = rem_q - den_ext;
      end
      den_d = den_q >> 1;
      quo_d = {quo_q[sfmc_pkg::QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// File: design/sfmc_ctrl.sv
// Sequencing state machine and handshake control for one tick request.
module sfmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sfmc_pkg::sts_t    sts_i,
  output sfmc_pkg::cmd_t    cmd_o
);

  localparam logic [sfmc_pkg::DivCntW-1:0] CntLast = sfmc_pkg::DivCntW'(sfmc_pkg::QuoW - 1);

  sfmc_pkg::state_e state_q, state_d;
  logic [sfmc_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfmc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sfmc_pkg::ST_EVAL;
      end
      sfmc_pkg::ST_EVAL: begin
        if (!sts_i.move) state_d = sfmc_pkg::ST_OUT;
        else if (sts_i.feed_need) state_d = sfmc_pkg::ST_FEED_DIV;
        else state_d = sfmc_pkg::ST_TARGET;
      end
      sfmc_pkg::ST_FEED_DIV: begin
        if (cnt_q == CntLast) state_d = sfmc_pkg::ST_TARGET;
      end
      sfmc_pkg::ST_TARGET: begin
        state_d = sts_i.ramp_need ? sfmc_pkg::ST_RAMP_DIV : sfmc_pkg::ST_OUT;
      end
      sfmc_pkg::ST_RAMP_DIV: begin
        if (cnt_q == CntLast) state_d = sfmc_pkg::ST_RAMP_END;
      end
      sfmc_pkg::ST_RAMP_END: begin
        state_d = sfmc_pkg::ST_OUT;
      end
      sfmc_pkg::ST_OUT: begin
        if (out_free) state_d = sfmc_pkg::ST_IDLE;
      end
      default: state_d = sfmc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sfmc_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      sfmc_pkg::ST_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.feed_load = sts_i.move && sts_i.feed_need;
      end
      sfmc_pkg::ST_FEED_DIV,
      sfmc_pkg::ST_RAMP_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      sfmc_pkg::ST_TARGET: begin
        cmd_o.target    = 1'b1;
        cmd_o.ramp_load = sts_i.ramp_need;
      end
      sfmc_pkg::ST_RAMP_END: begin
        cmd_o.ramp_take = 1'b1;
      end
      sfmc_pkg::ST_OUT: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.div_step) cnt_d = cnt_q + 1'b1;
    else cnt_d = '0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfmc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/sfmc_datapath.sv
// Controller state, configuration registers, feed scaling and PWM ramp datapath.
module sfmc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sfmc_pkg::cmd_t                    cmd_i,
  output sfmc_pkg::sts_t                    sts_o,
  input  sfmc_pkg::in_t                     in_data_i,
  output sfmc_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [sfmc_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [sfmc_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned AdcBits = sfmc_pkg::AdcBits;
  localparam int unsigned PwmW    = sfmc_pkg::PwmW;
  localparam int unsigned AccelW  = sfmc_pkg::AccelW;

  // configuration
  logic [AccelW-1:0]  accel_q;
  logic [AdcBits-1:0] feed_low_q;
  logic [AdcBits-1:0] feed_high_q;
  logic [PwmW-1:0]    up_speed_q;

  // block state
  sfmc_pkg::in_t      in_q;
  sfmc_pkg::mode_e    mode_q, mode_d;
  sfmc_pkg::led_e     led_q, led_d;
  logic               auto_q, auto_d;
  logic [AccelW-1:0]  elapsed_q, elapsed_d;
  logic [sfmc_pkg::SubW-1:0]  sub_q, sub_d;
  logic [sfmc_pkg::HundW-1:0] hund_q, hund_d;
  logic [PwmW-1:0]    pwm_q, pwm_d;
  logic [1:0]         dir_q, dir_d;
  logic               led_out_q, led_level;
  logic [PwmW-1:0]    tgt_q, tgt_d;
  logic               feed_pend_q;
  sfmc_pkg::out_t     out_q;

  logic               move, feed_need, ramp_need;
  logic [PwmW-1:0]    tgt_now;
  logic [AdcBits-1:0] feed_diff, feed_span;
  logic [AdcBits+PwmW-1:0] feed_prod;
  logic [AccelW+PwmW-1:0]  ramp_prod;
  logic                    div_load;
  logic [sfmc_pkg::DivNumW-1:0] div_num;
  logic [sfmc_pkg::DivDenW-1:0] div_den;
  logic [PwmW-1:0]              quo;

  // LED level from the state before this tick
  always_comb begin
    unique case (led_q)
      sfmc_pkg::LED_ON:          led_level = 1'b1;
      sfmc_pkg::LED_BLINK_SLOW:  led_level = (hund_q >= sfmc_pkg::HundHalf);
      sfmc_pkg::LED_BLINK_FAST:  led_level = hund_q[0];
      sfmc_pkg::LED_BLINK_RAPID: led_level = (sub_q >= sfmc_pkg::SubHalf);
      default:                   led_level = 1'b0;
    endcase
  end

  always_comb begin
    sub_d  = sub_q;
    hund_d = hund_q;
    if (cmd_i.eval) begin
      if (sub_q == sfmc_pkg::SubLast) begin
        sub_d  = '0;
        hund_d = (hund_q == sfmc_pkg::HundLast) ? '0 : hund_q + 1'b1;
      end else begin
        sub_d = sub_q + 1'b1;
      end
    end
  end

  // tick evaluation: events in order, then the mode action
  always_comb begin
    mode_d    = mode_q;
    auto_d    = auto_q;
    led_d     = led_q;
    elapsed_d = elapsed_q;
    dir_d     = dir_q;
    pwm_d     = pwm_q;
    tgt_d     = tgt_q;
    move      = 1'b0;
    feed_need = 1'b0;

    if (in_q.estop_released) mode_d = sfmc_pkg::MODE_IDLE;
    if (in_q.estop_held) mode_d = sfmc_pkg::MODE_ESTOP;
    if (in_q.up_short_release &&
        (mode_d == sfmc_pkg::MODE_UP || mode_d == sfmc_pkg::MODE_DOWN)) begin
      mode_d = sfmc_pkg::MODE_IDLE;
      auto_d = 1'b0;
    end
    if (in_q.up_long_press && mode_d == sfmc_pkg::MODE_UP) begin
      auto_d = 1'b1;
      led_d  = sfmc_pkg::LED_BLINK_FAST;
    end
    if (in_q.down_short_release &&
        (mode_d == sfmc_pkg::MODE_UP || mode_d == sfmc_pkg::MODE_DOWN)) begin
      mode_d = sfmc_pkg::MODE_IDLE;
      auto_d = 1'b0;
    end
    if (in_q.down_long_press && mode_d == sfmc_pkg::MODE_DOWN) begin
      auto_d = 1'b1;
      led_d  = sfmc_pkg::LED_BLINK_FAST;
    end

    unique case (mode_d)
      sfmc_pkg::MODE_ESTOP: begin
        pwm_d = '0;
        led_d = sfmc_pkg::LED_BLINK_RAPID;
      end
      sfmc_pkg::MODE_IDLE: begin
        auto_d = 1'b0;
        pwm_d  = '0;
        led_d  = sfmc_pkg::LED_BLINK_SLOW;
        if (in_q.up_held) begin
          mode_d    = sfmc_pkg::MODE_UP;
          led_d     = sfmc_pkg::LED_ON;
          elapsed_d = '0;
        end
        if (in_q.down_held) begin
          mode_d    = sfmc_pkg::MODE_DOWN;
          led_d     = sfmc_pkg::LED_ON;
          elapsed_d = '0;
        end
      end
      sfmc_pkg::MODE_UP: begin
        if (!in_q.top_limit_hit) begin
          move  = 1'b1;
          dir_d = 2'b01;
          tgt_d = up_speed_q;
        end else begin
          mode_d = sfmc_pkg::MODE_IDLE;
          pwm_d  = '0;
        end
      end
      sfmc_pkg::MODE_DOWN: begin
        if (!in_q.bottom_limit_hit) begin
          move  = 1'b1;
          dir_d = 2'b10;
          // low checked first: covers high <= low as well
          if (in_q.feed_adc <= feed_low_q) tgt_d = '0;
          else if (in_q.feed_adc >= feed_high_q) tgt_d = sfmc_pkg::FullSpeed;
          else feed_need = 1'b1;
        end else if (!auto_d) begin
          mode_d = sfmc_pkg::MODE_IDLE;
          pwm_d  = '0;
        end else begin
          // auto reversal: pwm and direction hold for this tick
          mode_d    = sfmc_pkg::MODE_UP;
          elapsed_d = '0;
        end
      end
      default: ;
    endcase

    if (move) begin
      elapsed_d = (elapsed_q == sfmc_pkg::ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
    end
  end

  assign tgt_now   = feed_pend_q ? quo : tgt_q;
  assign ramp_need = (accel_q != '0) && (elapsed_q < accel_q);

  // x * 255 as x * 256 - x
  assign feed_diff = in_q.feed_adc - feed_low_q;
  assign feed_span = feed_high_q - feed_low_q;
  assign feed_prod = {feed_diff, {PwmW{1'b0}}} - (AdcBits + PwmW)'(feed_diff);
  assign ramp_prod = elapsed_q * tgt_now;

  assign div_load = cmd_i.feed_load || cmd_i.ramp_load;
  always_comb begin
    if (cmd_i.ramp_load) begin
      div_num = sfmc_pkg::DivNumW'(ramp_prod);
      div_den = sfmc_pkg::DivDenW'(accel_q);
    end else begin
      div_num = sfmc_pkg::DivNumW'(feed_prod);
      div_den = sfmc_pkg::DivDenW'(feed_span);
    end
  end

  sfmc_div u_div (
    .clk_i  (clk_i),
    .load_i (div_load),
    .step_i (cmd_i.div_step),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (quo)
  );

  assign sts_o.move      = move;
  assign sts_o.feed_need = feed_need;
  assign sts_o.ramp_need = ramp_need;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q     <= sfmc_pkg::AccelReset;
      feed_low_q  <= sfmc_pkg::FeedLowReset;
      feed_high_q <= sfmc_pkg::FeedHiReset;
      up_speed_q  <= sfmc_pkg::UpSpeedReset;
    end else if (cfg_we_i) begin
      unique case (sfmc_pkg::cfg_idx_e'(cfg_addr_i))
        sfmc_pkg::CFG_ACCEL_MS:      accel_q     <= cfg_data_i[AccelW-1:0];
        sfmc_pkg::CFG_FEED_ADC_LOW:  feed_low_q  <= cfg_data_i[AdcBits-1:0];
        sfmc_pkg::CFG_FEED_ADC_HIGH: feed_high_q <= cfg_data_i[AdcBits-1:0];
        sfmc_pkg::CFG_UP_SPEED:      up_speed_q  <= cfg_data_i[PwmW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sfmc_pkg::MODE_IDLE;
      auto_q    <= 1'b0;
      led_q     <= sfmc_pkg::LED_BLINK_SLOW;
      elapsed_q <= '0;
      sub_q     <= '0;
      hund_q    <= '0;
      pwm_q     <= '0;
      dir_q     <= '0;
    end else begin
      sub_q  <= sub_d;
      hund_q <= hund_d;
      if (cmd_i.eval) begin
        mode_q    <= mode_d;
        auto_q    <= auto_d;
        led_q     <= led_d;
        elapsed_q <= elapsed_d;
        dir_q     <= dir_d;
        pwm_q     <= pwm_d;
      end else if (cmd_i.target && !ramp_need) begin
        pwm_q <= tgt_now;
      end else if (cmd_i.ramp_take) begin
        pwm_q <= quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) in_q <= in_data_i;
    if (cmd_i.eval) begin
      tgt_q       <= tgt_d;
      feed_pend_q <= feed_need;
      led_out_q   <= led_level;
    end
    if (cmd_i.out_load) begin
      out_q.motor_pwm   <= pwm_q;
      out_q.drive_up    <= dir_q[0];
      out_q.drive_down  <= dir_q[1];
      out_q.status_led  <= led_out_q;
      out_q.mode_now    <= 2'(mode_q);
      out_q.auto_active <= auto_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: design/saw_feed_motor_controller_top.sv
// Top level of the saw feed motor controller.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------
//  in       | request   | in_valid_i / in_ready_o | in_data_i  (in_t)
//  out      | result    | out_valid_o/out_ready_i | out_data_o (out_t)
//  cfg      | write     | cfg_we_i                | cfg_addr_i, cfg_data_i
//
// One tick request at a time. A tick with no move goes to the output load; a
// move sets its target with no, one (feed scaling or ramp) or two passes of the
// shared 8-step divider, which gives one quotient bit per cycle.
// Reset restores the configuration defaults and the idle state; no clearing pass.
// A result waits in the output register; the next request is taken meanwhile,
// and only its final output load waits for the register to free up.
module saw_feed_motor_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sfmc_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sfmc_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sfmc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [sfmc_pkg::CfgDataW-1:0] cfg_data_i
);

  sfmc_pkg::cmd_t cmd;
  sfmc_pkg::sts_t sts;

  sfmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sfmc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule
